// ===== hdl/nsfc_pkg.sv =====
package nsfc_pkg;

  localparam int unsigned NumRounds  = 4;
  localparam int unsigned BlockW     = 32;
  localparam int unsigned HalfW      = 16;
  localparam int unsigned KeyW       = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CheckRound = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROUND_KEY_0 = 2'd0,
    REG_ROUND_KEY_1 = 2'd1,
    REG_ROUND_KEY_2 = 2'd2,
    REG_ROUND_KEY_3 = 2'd3
  } nsfc_reg_t;

  // One block in flight, as it travels from cell to cell.
  typedef struct packed {
    logic [BlockW-1:0] blk;
    logic              chk_en;
    logic              known;
    logic              failed;
  } nsfc_item_t;

  localparam logic [3:0] NibbleTable [32] = '{
    4'h5, 4'h6, 4'h7, 4'h1, 4'h9, 4'hC, 4'hD, 4'h8,
    4'hA, 4'hD, 4'h2, 4'hB, 4'hF, 4'h4, 4'h0, 4'h3,
    4'hB, 4'h4, 4'h6, 4'h0, 4'hF, 4'h2, 4'hD, 4'h9,
    4'h5, 4'hC, 4'h1, 4'hA, 4'h3, 4'hD, 4'hE, 4'h8
  };

  function automatic logic [3:0] nibble_map(input logic [4:0] win);
    return NibbleTable[win];
  endfunction

endpackage

// ===== hdl/nsfc_if.sv =====
interface nsfc_in_if;
  import nsfc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BlockW-1:0] block_in;
  logic              check_enable;
  logic              known_lsb;

  modport source (output valid, output block_in, output check_enable, output known_lsb,
                  input ready);
  modport sink   (input valid, input block_in, input check_enable, input known_lsb,
                  output ready);
endinterface

interface nsfc_out_if;
  import nsfc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BlockW-1:0] block_out;
  logic              check_failed;

  modport source (output valid, output block_out, output check_failed, input ready);
  modport sink   (input valid, input block_out, input check_failed, output ready);
endinterface

interface nsfc_cfg_if;
  import nsfc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [KeyW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/nsfc_round.sv =====
module nsfc_round
  import nsfc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic [KeyW-1:0] key,
  input  logic            check_here,
  input  logic            up_vld,
  output logic            up_rdy,
  input  nsfc_item_t      up_item,
  output logic            dn_vld,
  input  logic            dn_rdy,
  output nsfc_item_t      dn_item
);

  logic       vld_r;
  nsfc_item_t item_r;
  nsfc_item_t item_nxt;

  logic [HalfW-1:0] lo, hi, v, f, f_rot;
  logic [3:0]       nib0;

  always_comb begin
    lo    = up_item.blk[HalfW-1:0];
    hi    = up_item.blk[BlockW-1:HalfW];
    v     = lo ^ key;
    nib0  = nibble_map(v[4:0]);
    f     = {nibble_map({v[0], v[15:12]}), nibble_map(v[12:8]),
             nibble_map(v[8:4]), nib0};
    f_rot = {f[2:0], f[HalfW-1:3]};

    item_nxt        = up_item;
    item_nxt.blk    = {lo, f_rot ^ hi};
    // flag a match of the known bit against bit 3 of the first window
    if (check_here && up_item.chk_en && (up_item.known == nib0[3])) begin
      item_nxt.failed = 1'b1;
    end
  end

  // advance when this stage is empty or its contents move on
  assign up_rdy = !vld_r || dn_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      item_r <= item_nxt;
    end
  end

  assign dn_vld  = vld_r;
  assign dn_item = item_r;

endmodule

// ===== hdl/nibble_sbox_feistel_cipher_32_unit.sv =====
// Four-round 32-bit Feistel cipher with 16-bit round keys.
//
// Channels: in_ch takes one request per block (block_in, check_enable,
// known_lsb); out_ch returns one result per request (block_out,
// check_failed), in order. cfg_ch writes round key 0..3 by index and is
// always ready; write keys only while no block is in flight. Decrypt by
// writing the keys in reverse order.
//
// A request accepted into the first cell passes through the round cells in
// order, each registering it, and the last cell presents it on out_ch.
// Throughput: one block per cycle while out_ch is ready; each round is
// one cell of a chain, and every cell holds its own block.
//
// Reset clears all cell valid bits and the four keys to zero.
// When the receiver stalls, the last cell holds its result and the cells
// before it keep filling empty slots, so up to four requests are taken
// before in_ch.ready drops. Ready of each cell is a function of its own
// valid bit and the next cell's ready.
module nibble_sbox_feistel_cipher_32_unit
  import nsfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  nsfc_in_if.sink     in_ch,
  nsfc_out_if.source  out_ch,
  nsfc_cfg_if.sink    cfg_ch
);

  logic [KeyW-1:0] key_r [NumRounds];

  // key registers; writes are taken every cycle
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumRounds; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_ch.valid) begin
      case (nsfc_reg_t'(cfg_ch.index))
        REG_ROUND_KEY_0: key_r[0] <= cfg_ch.data;
        REG_ROUND_KEY_1: key_r[1] <= cfg_ch.data;
        REG_ROUND_KEY_2: key_r[2] <= cfg_ch.data;
        REG_ROUND_KEY_3: key_r[3] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // chain links: link 0 is the input channel, link NumRounds the last cell
  logic       lnk_vld  [NumRounds+1];
  logic       lnk_rdy  [NumRounds+1];
  nsfc_item_t lnk_item [NumRounds+1];

  assign lnk_vld[0]  = in_ch.valid;
  assign lnk_item[0] = '{blk:    in_ch.block_in,
                         chk_en: in_ch.check_enable,
                         known:  in_ch.known_lsb,
                         failed: 1'b0};
  assign in_ch.ready = lnk_rdy[0];

  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    nsfc_round u_round (
      .clk        (clk),
      .rst_n      (rst_n),
      .key        (key_r[r]),
      .check_here (r == CheckRound),
      .up_vld     (lnk_vld[r]),
      .up_rdy     (lnk_rdy[r]),
      .up_item    (lnk_item[r]),
      .dn_vld     (lnk_vld[r+1]),
      .dn_rdy     (lnk_rdy[r+1]),
      .dn_item    (lnk_item[r+1])
    );
  end

  // last cell is the output register; apply the final half swap here
  assign lnk_rdy[NumRounds] = out_ch.ready;
  assign out_ch.valid       = lnk_vld[NumRounds];
  assign out_ch.block_out   = {lnk_item[NumRounds].blk[HalfW-1:0],
                               lnk_item[NumRounds].blk[BlockW-1:HalfW]};
  assign out_ch.check_failed = lnk_item[NumRounds].failed;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import nsfc_pkg::nsfc_reg_t;
  import nsfc_pkg::REG_ROUND_KEY_0;

  // Bench-side copies of the cipher constants.
  localparam int unsigned ROUNDS      = 4;
  localparam int unsigned CHECK_ROUND = 2;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam int unsigned DIR_ROWS    = 17;

  localparam logic [3:0] NIB_SUBST [32] = '{
    4'h5, 4'h6, 4'h7, 4'h1, 4'h9, 4'hC, 4'hD, 4'h8,
    4'hA, 4'hD, 4'h2, 4'hB, 4'hF, 4'h4, 4'h0, 4'h3,
    4'hB, 4'h4, 4'h6, 4'h0, 4'hF, 4'h2, 4'hD, 4'h9,
    4'h5, 4'hC, 4'h1, 4'hA, 4'h3, 4'hD, 4'hE, 4'h8
  };

  // Key sets for the directed part; set 0 is the reset state and never written.
  localparam logic [15:0] KEY_SETS [4][4] = '{
    '{16'h0000, 16'h0000, 16'h0000, 16'h0000},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{16'h0123, 16'h4567, 16'h89AB, 16'hCDEF},
    '{16'hCDEF, 16'h89AB, 16'h4567, 16'h0123}
  };

  typedef struct packed {
    logic [31:0] blk;
    logic        failed;
  } cipher_res_t;

  typedef struct packed {
    logic [1:0]  key_set;
    logic [31:0] blk;
    logic        chk_en;
    logic        known;
    logic        typed;
    logic [31:0] exp_blk;
    logic        exp_failed;
  } directed_row_t;

  // With all keys zero a zero block walks the table at fixed windows:
  // rounds give 0x5555, 0x2222, 0x9999 and 0xCCCC before rotation, so the
  // result is 0xDDDD9999 and the third-round nibble has bit 3 set.
  localparam directed_row_t DIRECTED [DIR_ROWS] = '{
    '{2'd0, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 32'hDDDD_9999, 1'b1},
    '{2'd0, 32'h0000_0000, 1'b1, 1'b0, 1'b1, 32'hDDDD_9999, 1'b0},
    '{2'd0, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 32'hDDDD_9999, 1'b0},
    '{2'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
    '{2'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0},
    '{2'd0, 32'h8000_0000, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0},
    '{2'd0, 32'h0000_0001, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
    '{2'd0, 32'hFFFF_0000, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{2'd0, 32'h0000_FFFF, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0},
    '{2'd1, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0},
    '{2'd1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
    '{2'd1, 32'hAAAA_AAAA, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0},
    '{2'd1, 32'h5555_5555, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0},
    '{2'd2, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'h0, 1'b0},
    '{2'd2, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0},
    '{2'd3, 32'h1234_5678, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0},
    '{2'd3, 32'h0F0F_0F0F, 1'b1, 1'b1, 1'b0, 32'h0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;

  nsfc_in_if  in_bus ();
  nsfc_out_if out_bus ();
  nsfc_cfg_if cfg_bus ();

  nibble_sbox_feistel_cipher_32_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // Shadow of the round keys, updated at each accepted write.
  logic [15:0] round_keys [ROUNDS];
  cipher_res_t pending_ciphers [$];
  cipher_res_t oldest_cipher;
  int unsigned error_count = 0;
  logic        in_idle_en  = 1'b0;
  logic        out_stall_en = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run all four rounds on one request with the current keys.
  function automatic cipher_res_t encipher_block(input logic [31:0] blk_in,
                                                 input logic chk_en, input logic known);
    logic [31:0] blk;
    logic [31:0] dup;
    logic [15:0] lo, hi, v, f;
    logic [3:0]  nib;
    cipher_res_t res;
    blk = blk_in;
    res.failed = 1'b0;
    for (int r = 0; r < ROUNDS; r++) begin
      lo = blk[15:0];
      hi = blk[31:16];
      v = lo ^ round_keys[r];
      dup = {v, v};
      f = '0;
      for (int n = 0; n < 4; n++) begin
        nib = NIB_SUBST[dup[n*4 +: 5]];
        f[n*4 +: 4] = nib;
        // Flag the known-data parity check on the first window of round three.
        if (n == 0 && r == CHECK_ROUND && chk_en && known == nib[3])
          res.failed = 1'b1;
      end
      f = {f[2:0], f[15:3]};
      blk = {lo, f ^ hi};
    end
    res.blk = {blk[15:0], blk[31:16]};
    return res;
  endfunction

  // Drive one key write and wait for its handshake.
  task automatic write_round_key(input nsfc_reg_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    round_keys[idx] = value;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Hold valid low for an idle gap set by n; scramble the payload meanwhile.
  task automatic idle_input(input int unsigned n);
    @(negedge clk);
    in_bus.valid    <= 1'b0;
    in_bus.block_in <= $urandom;
    repeat (n - 1) @(negedge clk);
  endtask

  // Offer one request, hold it until accepted, then queue its expectation.
  task automatic push_block(input logic [31:0] blk, input logic chk_en, input logic known,
                            input logic typed, input cipher_res_t typed_res);
    @(negedge clk);
    in_bus.valid        <= 1'b1;
    in_bus.block_in     <= blk;
    in_bus.check_enable <= chk_en;
    in_bus.known_lsb    <= known;
    do @(posedge clk); while (!in_bus.ready);
    pending_ciphers = {pending_ciphers,
                       typed ? typed_res : encipher_block(blk, chk_en, known)};
  endtask

  // Drop valid and wait until every queued result has come back.
  task automatic settle_pipeline();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_ciphers.size() != 0) @(posedge clk);
  endtask

  // Result checker: compare each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_ciphers.size() == 0) begin
        $error("unexpected result: block_out %08h, check_failed %0b",
               out_bus.block_out, out_bus.check_failed);
        error_count++;
      end else begin
        oldest_cipher = pending_ciphers.pop_front();
        if (out_bus.block_out !== oldest_cipher.blk) begin
          $error("block_out: expected %08h, got %08h", oldest_cipher.blk, out_bus.block_out);
          error_count++;
        end
        if (out_bus.check_failed !== oldest_cipher.failed) begin
          $error("check_failed: expected %0b, got %0b",
                 oldest_cipher.failed, out_bus.check_failed);
          error_count++;
        end
      end
    end
  end

  // Receiver: stall in random bursts while enabled, otherwise always take results.
  initial begin
    out_bus.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (out_stall_en && $urandom_range(0, 3) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Main sequence: reset, directed table, then random phases that each reload the keys.
  initial begin
    logic [1:0]  cur_set;
    logic [15:0] next_keys [ROUNDS];
    logic [31:0] blk;
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.block_in     = '0;
    in_bus.check_enable = 1'b0;
    in_bus.known_lsb    = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = REG_ROUND_KEY_0;
    cfg_bus.data        = '0;
    for (int k = 0; k < ROUNDS; k++) round_keys[k] = '0;
    cur_set = 2'd0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: walk the table, reloading keys when the set changes.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].key_set != cur_set) begin
        settle_pipeline();
        cur_set = DIRECTED[i].key_set;
        for (int k = 0; k < ROUNDS; k++)
          write_round_key(nsfc_reg_t'(k), KEY_SETS[cur_set][k]);
      end
      push_block(DIRECTED[i].blk, DIRECTED[i].chk_en, DIRECTED[i].known, DIRECTED[i].typed,
                 '{blk: DIRECTED[i].exp_blk, failed: DIRECTED[i].exp_failed});
    end

    // Random part: each phase drains the pipeline, then loads new keys.
    // Odd phases load the previous keys reversed, the deciphering key order.
    for (int p = 0; p < PHASES; p++) begin
      settle_pipeline();
      for (int k = 0; k < ROUNDS; k++) begin
        if (p % 2 == 1) begin
          next_keys[k] = round_keys[ROUNDS - 1 - k];
        end else begin
          case ($urandom_range(0, 5))
            0:       next_keys[k] = 16'h0000;
            1:       next_keys[k] = 16'hFFFF;
            default: next_keys[k] = 16'($urandom);
          endcase
        end
      end
      for (int k = 0; k < ROUNDS; k++)
        write_round_key(nsfc_reg_t'(k), next_keys[k]);

      // Keep one early phase and the last one free of any idling.
      in_idle_en   = (p != 2) && (p != PHASES - 1);
      out_stall_en = (p != 2) && (p != PHASES - 1);

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (in_idle_en && $urandom_range(0, 3) == 0)
          idle_input($urandom_range(1, 13));
        case ($urandom_range(0, 9))
          0:       blk = 32'h0000_0000;
          1:       blk = 32'hFFFF_FFFF;
          default: blk = $urandom;
        endcase
        push_block(blk, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
      end
    end

    // Wait for the tail, then let the pipeline run idle before the verdict.
    settle_pipeline();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("** nibble_sbox_feistel_cipher_32_unit: PASSED **");
    end else begin
      $display("** nibble_sbox_feistel_cipher_32_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("** nibble_sbox_feistel_cipher_32_unit: FAILED **");
    $finish;
  end

endmodule
